/* rtl/pat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg
// shared types, codes and field widths for the paged allocator / translator
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int ADDR_W      = 22;
  localparam int BYTE_W      = 23;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 32;

  localparam int DEF_PAGE_OFFSET_BITS = 12;
  localparam int DEF_PAGE_COUNT       = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_XLATE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_NO_RUN     = 3'd1,
    STAT_NO_FRAME   = 3'd2,
    STAT_MISALIGNED = 3'd3,
    STAT_UNMAPPED   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_CNT_RD,
    ST_CNT,
    ST_MAP_RD,
    ST_MAP,
    ST_FREE_RD,
    ST_FREE,
    ST_XLATE_RD,
    ST_XLATE,
    ST_DONE
  } state_t;

endpackage

/* rtl/paged_allocator_translator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_allocator_translator_top
// page allocator with virtual/frame bitmaps and a page table, plus translation
// ----------------------------------------------------------------------------
// channel  dir  bus                        contents
// s_*      in   s_tdata[47:0], s_tuser     address, byte_count / kind
// m_*      out  m_tdata[31:0]              status, result_address
//
// one request at a time; every request gives exactly one result transaction
// steps: translate reads the page table; free walks each released page; alloc
//   scans virtual pages for a run, counts free frames over all PAGE_COUNT, then
//   probes frames while mapping; the bitmap ram read port sets the pace
// after reset a clearing pass over all PAGE_COUNT entries wipes both bitmaps;
//   s_tready stays low until it ends
// a held result on m_* stalls only the hand-off of the next result
// ----------------------------------------------------------------------------
module paged_allocator_translator_top #(
  parameter int PAGE_OFFSET_BITS = pat_pkg::DEF_PAGE_OFFSET_BITS,
  parameter int PAGE_COUNT       = pat_pkg::DEF_PAGE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pat_pkg::S_TDATA_W-1:0] s_tdata,  // address[21:0], byte_count[44:22]
  input  logic [pat_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pat_pkg::M_TDATA_W-1:0] m_tdata   // status[2:0], result_address[24:3]
);

  localparam int AW     = pat_pkg::ADDR_W;
  localparam int POB    = PAGE_OFFSET_BITS;
  localparam int PN_W   = $clog2(PAGE_COUNT);
  localparam int BSUM_W = pat_pkg::BYTE_W + 1;
  localparam int NW     = BSUM_W - POB;
  localparam int CW     = ((NW > PN_W + 1) ? NW : PN_W + 1) + 1;
  localparam int XW     = PN_W + AW;
  localparam int PAD_W  = pat_pkg::M_TDATA_W - pat_pkg::STATUS_W - AW;

  pat_pkg::state_t  state, state_next;
  pat_pkg::status_t status_r, status_next, out_status;
  logic [AW-1:0]    addr_r, addr_next;
  logic [AW-1:0]    result_r, result_next, out_result;
  logic [CW-1:0]    n_r, n_next;
  logic [CW-1:0]    i, i_next;
  logic [CW-1:0]    run, run_next;
  logic [CW-1:0]    start, start_next;
  logic [CW-1:0]    f, f_next;
  logic [CW-1:0]    k, k_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             out_load;

  // bitmap and page table ports
  logic            vu_we, vu_wdata, vu_rdata;
  logic [PN_W-1:0] vu_waddr, vu_raddr;
  logic            fu_we, fu_wdata, fu_rdata;
  logic [PN_W-1:0] fu_waddr, fu_raddr;
  logic            pt_we;
  logic [PN_W-1:0] pt_waddr, pt_raddr, pt_wdata, pt_rdata;

  // request decode
  logic [AW-1:0]            s_addr;
  logic [BSUM_W-1:0]        bsum;
  logic [CW-1:0]            s_pages;
  logic [CW-1:0]            vpn, page, run_inc, cnt_inc, map_page;
  logic [XW-1:0]            xlate_wide, alloc_wide, off_wide;

  assign s_addr  = s_tdata[AW-1:0];
  assign bsum    = BSUM_W'(s_tdata[AW +: pat_pkg::BYTE_W]) + BSUM_W'((1 << POB) - 1);
  assign s_pages = CW'(bsum >> POB);

  assign vpn      = CW'(addr_r[AW-1:POB]);
  assign page     = vpn + i;
  assign run_inc  = vu_rdata ? '0 : run + CW'(1);
  assign cnt_inc  = cnt + CW'(!fu_rdata);
  assign map_page = start + k;

  assign off_wide   = XW'(addr_r) & ((XW'(1) << POB) - XW'(1));
  assign xlate_wide = (XW'(pt_rdata) << POB) | off_wide;
  assign alloc_wide = XW'(start) << POB;

  pat_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_vused (
    .clk(clk), .we(vu_we), .waddr(vu_waddr), .wdata(vu_wdata),
    .raddr(vu_raddr), .rdata(vu_rdata)
  );

  pat_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_fused (
    .clk(clk), .we(fu_we), .waddr(fu_waddr), .wdata(fu_wdata),
    .raddr(fu_raddr), .rdata(fu_rdata)
  );

  pat_ram #(.WIDTH(PN_W), .DEPTH(PAGE_COUNT)) u_ptable (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  assign s_tready = (state == pat_pkg::ST_IDLE);
  assign m_tdata  = {{PAD_W{1'b0}}, out_result, out_status};

  always_comb begin
    state_next  = state;
    addr_next   = addr_r;
    n_next      = n_r;
    i_next      = i;
    run_next    = run;
    start_next  = start;
    f_next      = f;
    k_next      = k;
    cnt_next    = cnt;
    status_next = status_r;
    result_next = result_r;
    out_load    = 1'b0;
    vu_we       = 1'b0;
    vu_waddr    = i[PN_W-1:0];
    vu_wdata    = 1'b0;
    vu_raddr    = i[PN_W-1:0];
    fu_we       = 1'b0;
    fu_waddr    = i[PN_W-1:0];
    fu_wdata    = 1'b0;
    fu_raddr    = i[PN_W-1:0];
    pt_we       = 1'b0;
    pt_waddr    = map_page[PN_W-1:0];
    pt_wdata    = f[PN_W-1:0];
    pt_raddr    = page[PN_W-1:0];

    unique case (state)
      pat_pkg::ST_CLEAR: begin
        // wipe both bitmaps, one entry a cycle
        vu_we = 1'b1;
        fu_we = 1'b1;
        if (i == CW'(PAGE_COUNT - 1)) begin
          i_next     = '0;
          state_next = pat_pkg::ST_IDLE;
        end else begin
          i_next = i + CW'(1);
        end
      end

      pat_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          addr_next   = s_addr;
          n_next      = s_pages;
          status_next = pat_pkg::STAT_OK;
          result_next = '0;
          i_next      = '0;
          run_next    = '0;
          state_next  = pat_pkg::ST_DONE;
          case (s_tuser)
            pat_pkg::KIND_ALLOC: begin
              if (s_pages == '0) begin
                result_next = AW'(XW'(1) << POB);
              end else begin
                i_next     = CW'(1);
                state_next = pat_pkg::ST_SCAN_RD;
              end
            end
            pat_pkg::KIND_FREE: begin
              if (s_addr[POB-1:0] != '0) begin
                status_next = pat_pkg::STAT_MISALIGNED;
              end else if (s_pages != '0) begin
                state_next = pat_pkg::ST_FREE_RD;
              end
            end
            pat_pkg::KIND_XLATE: begin
              state_next = pat_pkg::ST_XLATE_RD;
            end
            default: begin
              state_next = pat_pkg::ST_DONE;
            end
          endcase
        end
      end

      pat_pkg::ST_SCAN_RD: begin
        state_next = pat_pkg::ST_SCAN;
      end

      pat_pkg::ST_SCAN: begin
        run_next = run_inc;
        if (run_inc == n_r) begin
          start_next = i + CW'(1) - n_r;
          i_next     = '0;
          cnt_next   = '0;
          state_next = pat_pkg::ST_CNT_RD;
        end else if (i == CW'(PAGE_COUNT - 1)) begin
          status_next = pat_pkg::STAT_NO_RUN;
          state_next  = pat_pkg::ST_DONE;
        end else begin
          i_next     = i + CW'(1);
          state_next = pat_pkg::ST_SCAN_RD;
        end
      end

      pat_pkg::ST_CNT_RD: begin
        state_next = pat_pkg::ST_CNT;
      end

      pat_pkg::ST_CNT: begin
        cnt_next = cnt_inc;
        if (i == CW'(PAGE_COUNT - 1)) begin
          if (cnt_inc < n_r) begin
            status_next = pat_pkg::STAT_NO_FRAME;
            state_next  = pat_pkg::ST_DONE;
          end else begin
            f_next     = '0;
            k_next     = '0;
            state_next = pat_pkg::ST_MAP_RD;
          end
        end else begin
          i_next     = i + CW'(1);
          state_next = pat_pkg::ST_CNT_RD;
        end
      end

      pat_pkg::ST_MAP_RD: begin
        fu_raddr   = f[PN_W-1:0];
        state_next = pat_pkg::ST_MAP;
      end

      pat_pkg::ST_MAP: begin
        f_next = f + CW'(1);
        if (fu_rdata) begin
          state_next = pat_pkg::ST_MAP_RD;
        end else begin
          fu_we    = 1'b1;
          fu_waddr = f[PN_W-1:0];
          fu_wdata = 1'b1;
          vu_we    = 1'b1;
          vu_waddr = map_page[PN_W-1:0];
          vu_wdata = 1'b1;
          pt_we    = 1'b1;
          k_next   = k + CW'(1);
          if (k + CW'(1) == n_r) begin
            result_next = alloc_wide[AW-1:0];
            state_next  = pat_pkg::ST_DONE;
          end else begin
            state_next = pat_pkg::ST_MAP_RD;
          end
        end
      end

      pat_pkg::ST_FREE_RD: begin
        vu_raddr = page[PN_W-1:0];
        if (page >= CW'(PAGE_COUNT)) begin
          status_next = pat_pkg::STAT_UNMAPPED;
          state_next  = pat_pkg::ST_DONE;
        end else begin
          state_next = pat_pkg::ST_FREE;
        end
      end

      pat_pkg::ST_FREE: begin
        if (!vu_rdata) begin
          status_next = pat_pkg::STAT_UNMAPPED;
          state_next  = pat_pkg::ST_DONE;
        end else begin
          vu_we    = 1'b1;
          vu_waddr = page[PN_W-1:0];
          fu_we    = 1'b1;
          fu_waddr = pt_rdata;
          if (i + CW'(1) == n_r) begin
            state_next = pat_pkg::ST_DONE;
          end else begin
            i_next     = i + CW'(1);
            state_next = pat_pkg::ST_FREE_RD;
          end
        end
      end

      pat_pkg::ST_XLATE_RD: begin
        vu_raddr = vpn[PN_W-1:0];
        pt_raddr = vpn[PN_W-1:0];
        if (vpn >= CW'(PAGE_COUNT)) begin
          status_next = pat_pkg::STAT_UNMAPPED;
          state_next  = pat_pkg::ST_DONE;
        end else begin
          state_next = pat_pkg::ST_XLATE;
        end
      end

      pat_pkg::ST_XLATE: begin
        state_next = pat_pkg::ST_DONE;
        if (!vu_rdata) begin
          status_next = pat_pkg::STAT_UNMAPPED;
        end else begin
          result_next = xlate_wide[AW-1:0];
        end
      end

      pat_pkg::ST_DONE: begin
        // hand the result to the output register once it is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = pat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = pat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pat_pkg::ST_CLEAR;
      i        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      i     <= i_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_next;
    n_r      <= n_next;
    run      <= run_next;
    start    <= start_next;
    f        <= f_next;
    k        <= k_next;
    cnt      <= cnt_next;
    status_r <= status_next;
    result_r <= result_next;
    if (out_load) begin
      out_status <= status_r;
      out_result <= result_r;
    end
  end

endmodule

/* rtl/pat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pat_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_checker
// port-level checks for the paged allocator / translator
// ----------------------------------------------------------------------------
module pat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [pat_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [pat_pkg::KIND_W-1:0]    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pat_pkg::M_TDATA_W-1:0] m_tdata
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clearing pass keeps the input closed right after reset
  a_reset_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open during clearing pass");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // error results carry a zero address
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != pat_pkg::STAT_OK) |-> m_tdata[24:3] == '0)
    else $error("error result with nonzero address");

  // status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] == pat_pkg::STAT_OK
              || m_tdata[2:0] == pat_pkg::STAT_NO_RUN
              || m_tdata[2:0] == pat_pkg::STAT_NO_FRAME
              || m_tdata[2:0] == pat_pkg::STAT_MISALIGNED
              || m_tdata[2:0] == pat_pkg::STAT_UNMAPPED)
    else $error("undefined status code");

endmodule

bind paged_allocator_translator_top pat_checker u_pat_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the paged allocator / translator: a directed table
// of requests followed by random alloc/free/translate traffic, every result
// transaction checked vs a typed-in answer or a page table/bitmap predictor
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OFFS  = pat_pkg::DEF_PAGE_OFFSET_BITS;
  localparam int PAGES = pat_pkg::DEF_PAGE_COUNT;
  localparam int PN_W  = $clog2(PAGES);
  localparam int PAGE_BYTES = 1 << OFFS;
  localparam int CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    pat_pkg::kind_t              kind;
    logic [pat_pkg::ADDR_W-1:0]  address;
    logic [pat_pkg::BYTE_W-1:0]  byte_count;
  } request_t;

  typedef struct packed {
    pat_pkg::status_t            status;
    logic [pat_pkg::ADDR_W-1:0]  result_address;
  } answer_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    request_t req;
    bit       fixed;
    answer_t  ans;
  } row_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [pat_pkg::S_TDATA_W-1:0] s_tdata;
  logic [pat_pkg::KIND_W-1:0]    s_tuser;
  logic [pat_pkg::M_TDATA_W-1:0] m_tdata;

  paged_allocator_translator_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state
  bit              vpage_used [PAGES];
  bit              frame_busy [PAGES];
  logic [PN_W-1:0] page_frame [PAGES];

  answer_t pending_answers[$];
  int      fail_count = 0;
  longint  cycle_count = 0;

  // live allocations, for well-formed frees and translates
  int live_base[$];
  int live_pages[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pages_of(logic [pat_pkg::BYTE_W-1:0] bytes);
    return (int'(bytes) + PAGE_BYTES - 1) >> OFFS;
  endfunction

  // compute the result of one request and update the page state
  function automatic answer_t page_service(request_t r);
    answer_t a;
    int n, run, start, free_frames, f, vpn;
    bit found;
    a.status = pat_pkg::STAT_OK;
    a.result_address = '0;
    run = 0; start = 0; free_frames = 0; f = 0; found = 0;
    case (r.kind)
      pat_pkg::KIND_ALLOC: begin
        n = pages_of(r.byte_count);
        if (n == 0) begin
          a.result_address = pat_pkg::ADDR_W'(PAGE_BYTES);
        end else begin
          for (int i = 1; i < PAGES && !found; i++) begin
            run = vpage_used[i] ? 0 : run + 1;
            if (run == n) begin
              start = i + 1 - n;
              found = 1;
            end
          end
          if (!found) a.status = pat_pkg::STAT_NO_RUN;
          else begin
            foreach (frame_busy[i]) if (!frame_busy[i]) free_frames++;
            if (free_frames < n) a.status = pat_pkg::STAT_NO_FRAME;
            else begin
              for (int i = 0; i < n; i++) begin
                while (frame_busy[f]) f++;
                frame_busy[f] = 1;
                vpage_used[start + i] = 1;
                page_frame[start + i] = PN_W'(f);
              end
              a.result_address = pat_pkg::ADDR_W'(start << OFFS);
            end
          end
        end
      end
      pat_pkg::KIND_FREE: begin
        n = pages_of(r.byte_count);
        vpn = int'(r.address) >> OFFS;
        if ((int'(r.address) & (PAGE_BYTES - 1)) != 0) a.status = pat_pkg::STAT_MISALIGNED;
        else begin
          for (int i = 0; i < n; i++) begin
            if (vpn + i >= PAGES || !vpage_used[vpn + i]) begin
              a.status = pat_pkg::STAT_UNMAPPED;
              break;
            end
            vpage_used[vpn + i] = 0;
            frame_busy[page_frame[vpn + i]] = 0;
          end
        end
      end
      pat_pkg::KIND_XLATE: begin
        vpn = int'(r.address) >> OFFS;
        if (vpn >= PAGES || !vpage_used[vpn]) a.status = pat_pkg::STAT_UNMAPPED;
        else a.result_address = pat_pkg::ADDR_W'((int'(page_frame[vpn]) << OFFS)
                                                 | (int'(r.address) & (PAGE_BYTES - 1)));
      end
      default: ;
    endcase
    return a;
  endfunction

  // hand one request to the block; prediction happens at acceptance
  task automatic send_request(request_t r, bit fixed, answer_t fixed_ans);
    answer_t a;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b0, r.byte_count, r.address};
    s_tuser  <= r.kind;
    do @(posedge clk); while (!s_tready);
    a = page_service(r);
    if (fixed && a !== fixed_ans)
      $display("%0t predictor disagrees with table: expected %h actual %h",
               $time, fixed_ans, a);
    pending_answers.push_back(fixed ? fixed_ans : a);
    if (r.kind == pat_pkg::KIND_ALLOC && a.status == pat_pkg::STAT_OK
        && r.byte_count != 0) begin
      live_base.push_back(int'(a.result_address));
      live_pages.push_back(pages_of(r.byte_count));
    end
  endtask

  // sender: bursts of random length then random gaps
  int burst_left;
  task automatic pace_and_send(request_t r);
    answer_t none;
    none = '0;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_request(r, 1'b0, none);
  endtask

  function automatic request_t make_req(pat_pkg::kind_t k, int addr, int bytes);
    request_t r;
    r.kind = k;
    r.address = pat_pkg::ADDR_W'(addr);
    r.byte_count = pat_pkg::BYTE_W'(bytes);
    return r;
  endfunction

  function automatic row_t row(pat_pkg::kind_t k, int addr, int bytes, bit fx = 0,
                               pat_pkg::status_t st = pat_pkg::STAT_OK, int ra = 0);
    row_t w;
    w.req = make_req(k, addr, bytes);
    w.fixed = fx;
    w.ans.status = st;
    w.ans.result_address = pat_pkg::ADDR_W'(ra);
    return w;
  endfunction

  // random request, mostly well-formed against live allocations
  function automatic request_t random_request();
    int sel, idx, base, n;
    sel = $urandom_range(0, 99);
    if (live_base.size() > 0) begin
      idx = $urandom_range(0, live_base.size() - 1);
      base = live_base[idx];
      n = live_pages[idx];
    end else begin
      base = PAGE_BYTES;
      n = 1;
    end
    if (sel < 35) begin
      // small sizes mostly, a rare huge one
      if ($urandom_range(0, 19) == 0)
        return make_req(pat_pkg::KIND_ALLOC, $urandom, $urandom_range(0, (1 << 23) - 1));
      return make_req(pat_pkg::KIND_ALLOC, $urandom, $urandom_range(0, 8 * PAGE_BYTES));
    end
    if (sel < 55) begin
      if (live_base.size() > 0) begin
        live_base.delete(idx);
        live_pages.delete(idx);
      end
      return make_req(pat_pkg::KIND_FREE, base,
                      $urandom_range((n - 1) * PAGE_BYTES + 1, n * PAGE_BYTES));
    end
    if (sel < 85)
      return make_req(pat_pkg::KIND_XLATE, base + $urandom_range(0, n * PAGE_BYTES - 1),
                      $urandom);
    if (sel < 92)
      return make_req(pat_pkg::KIND_FREE, $urandom_range(0, (1 << pat_pkg::ADDR_W) - 1),
                      $urandom_range(0, 4 * PAGE_BYTES));
    if (sel < 97)
      return make_req(pat_pkg::KIND_XLATE, $urandom_range(0, (1 << pat_pkg::ADDR_W) - 1),
                      $urandom);
    return make_req(pat_pkg::kind_t'(2'd3), $urandom, $urandom);
  endfunction

  // result checker and receiver stall pattern
  answer_t got, want;
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      // quiet stretches alternate with random stalling
      m_tready <= (stall_phase[8]) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (m_tvalid && m_tready) begin
        got.status = pat_pkg::status_t'(m_tdata[2:0]);
        got.result_address = m_tdata[24:3];
        if (pending_answers.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, got);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status) begin
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.result_address !== want.result_address) begin
            $display("%0t result_address mismatch: expected %h actual %h",
                     $time, want.result_address, got.result_address);
            fail_count++;
          end
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("paged_allocator_translator_top test failed");
      $finish;
    end
  end

  row_t directed[$];

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // after reset nothing is mapped; first one-page alloc lands on page 1, frame 0
    directed.push_back(row(pat_pkg::KIND_XLATE, 0, 0, 1, pat_pkg::STAT_UNMAPPED, 0));
    directed.push_back(row(pat_pkg::KIND_XLATE, 22'h3FFFFF, 0, 1, pat_pkg::STAT_UNMAPPED, 0));
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, 0, 1, pat_pkg::STAT_OK, PAGE_BYTES));
    directed.push_back(row(pat_pkg::KIND_ALLOC, 22'h3FFFFF, 1, 1, pat_pkg::STAT_OK, PAGE_BYTES));
    directed.push_back(row(pat_pkg::KIND_XLATE, PAGE_BYTES + 22'h123, 0, 1,
                           pat_pkg::STAT_OK, 22'h123));
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, PAGE_BYTES + 1));
    directed.push_back(row(pat_pkg::KIND_XLATE, 3 * PAGE_BYTES + PAGE_BYTES - 1, 0));
    // runs as long as or longer than the address space
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, 23'h7FFFFF, 1, pat_pkg::STAT_NO_RUN, 0));
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, 23'h400000, 1, pat_pkg::STAT_NO_RUN, 0));
    directed.push_back(row(pat_pkg::KIND_FREE, PAGE_BYTES + 1, PAGE_BYTES, 1,
                           pat_pkg::STAT_MISALIGNED, 0));
    directed.push_back(row(pat_pkg::KIND_FREE, PAGE_BYTES, 0, 1, pat_pkg::STAT_OK, 0));
    // free walks off the mapped run into page 4
    directed.push_back(row(pat_pkg::KIND_FREE, 2 * PAGE_BYTES, 3 * PAGE_BYTES));
    directed.push_back(row(pat_pkg::KIND_XLATE, 2 * PAGE_BYTES, 0, 1,
                           pat_pkg::STAT_UNMAPPED, 0));
    directed.push_back(row(pat_pkg::KIND_FREE, 0, PAGE_BYTES, 1, pat_pkg::STAT_UNMAPPED, 0));
    directed.push_back(row(pat_pkg::KIND_FREE, 22'h3FF000, PAGE_BYTES, 1,
                           pat_pkg::STAT_UNMAPPED, 0));
    directed.push_back(row(pat_pkg::kind_t'(2'd3), 22'h3FFFFF, 23'h7FFFFF, 1,
                           pat_pkg::STAT_OK, 0));
    // fill the whole space: 1022 more pages fit, then no run is left for more
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, 1022 * PAGE_BYTES));
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, PAGE_BYTES, 1, pat_pkg::STAT_NO_RUN, 0));
    directed.push_back(row(pat_pkg::KIND_FREE, PAGE_BYTES, 1023 * PAGE_BYTES));
    directed.push_back(row(pat_pkg::KIND_XLATE, 22'h3FFFFF, 0));
    directed.push_back(row(pat_pkg::KIND_FREE, 22'h3FF000, 23'h400000));
    directed.push_back(row(pat_pkg::KIND_ALLOC, 0, PAGE_BYTES));
    directed.push_back(row(pat_pkg::KIND_FREE, PAGE_BYTES, PAGE_BYTES));

    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].fixed, directed[i].ans);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    live_base.delete();
    live_pages.delete();
    // rebuild live list from the predictor so random frees stay well-formed
    for (int p = 1; p < PAGES; p++)
      if (vpage_used[p]) begin
        live_base.push_back(p << OFFS);
        live_pages.push_back(1);
      end

    repeat (267) pace_and_send(random_request());
    s_tvalid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("paged_allocator_translator_top test passed");
    else $display("paged_allocator_translator_top test failed");
    $finish;
  end

endmodule
